// ----- hdl/glyph_code_pair_allocator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GLYPH_CODE_PAIR_ALLOCATOR_DEFINES_SVH
`define GLYPH_CODE_PAIR_ALLOCATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define GCPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define GCPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also applies while reset is asserted
`define GCPA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/gcpa_pkg.sv -----
`timescale 1ns / 1ps
package gcpa_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CODE_W      = 9;

    localparam logic [CODE_W-1:0] CODE_RESET = 9'd1;
    localparam logic [CODE_W-1:0] CODE_SKIP  = 9'h00D;
    localparam logic [CODE_W-1:0] GAP_LOW    = 9'h01E;
    localparam logic [CODE_W-1:0] GAP_HIGH   = 9'd128;
    localparam logic [15:0]       COUNT_MAX  = 16'hFFFF;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STAT_HIT  = 2'd0,
        STAT_NEW  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_RES
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        cmp_en;
        logic [15:0] key;
        logic        inc;
        logic        wr;
        logic [15:0] codes;
    } cell_cmd_t;

    // per-cell search answer, all zero unless the cell matched
    typedef struct packed {
        logic              hit;
        logic [15:0]       codes;
        logic [15:0]       count;
        logic [SLOT_W-1:0] slot;
    } cell_res_t;

    function automatic logic [CODE_W-1:0] advance_code(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] n;
        n = c + 1'b1;
        if (n == CODE_SKIP) begin
            n = n + 1'b1;
        end
        if (n >= GAP_LOW && n < GAP_HIGH) begin
            n = GAP_HIGH;
        end
        return n;
    endfunction

endpackage

// ----- hdl/gcpa_cell.sv -----
`timescale 1ns / 1ps
module gcpa_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [gcpa_pkg::SLOT_W-1:0] idx,
    input  logic                       prev_occ,
    output logic                       occ,
    input  gcpa_pkg::cell_cmd_t        cmd,
    output gcpa_pkg::cell_res_t        res
);
    import gcpa_pkg::*;

    logic              occ_reg;
    logic              hit_reg;
    logic [15:0]       key_reg;
    logic [15:0]       codes_reg;
    logic [15:0]       count_reg;
    logic [15:0]       count_next;
    logic [15:0]       res_codes_reg;
    logic [15:0]       res_count_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              take;
    logic              match;

    // occupancy is a thermometer along the row: the first free cell takes a write
    assign take  = cmd.wr && prev_occ && !occ_reg;
    assign match = occ_reg && (key_reg == cmd.key);

    always_comb begin
        count_next = count_reg;
        if (take) begin
            count_next = 16'd1;
        end else if (cmd.inc && hit_reg && count_reg != COUNT_MAX) begin
            count_next = count_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            if (take) begin
                occ_reg <= 1'b1;
            end
            if (cmd.cmp_en) begin
                hit_reg <= match;
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        if (take) begin
            key_reg   <= cmd.key;
            codes_reg <= cmd.codes;
        end
        if (cmd.cmp_en) begin
            res_codes_reg <= match ? codes_reg : 16'd0;
            res_count_reg <= match ? count_reg : 16'd0;
            res_slot_reg  <= match ? idx : '0;
        end
    end

    assign occ       = occ_reg;
    assign res.hit   = hit_reg;
    assign res.codes = res_codes_reg;
    assign res.count = res_count_reg;
    assign res.slot  = res_slot_reg;

endmodule

// ----- hdl/gcpa_group.sv -----
`timescale 1ns / 1ps
module gcpa_group (
    input  logic                aclk,
    input  logic                aresetn,
    input  gcpa_pkg::cell_res_t cell_res [gcpa_pkg::GROUP_SIZE],
    output gcpa_pkg::cell_res_t grp_res
);
    import gcpa_pkg::*;

    cell_res_t acc;
    cell_res_t grp_reg;

    // keys are unique, so at most one cell answers and an OR picks it out
    always_comb begin
        acc = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            acc = cell_res_t'(acc | cell_res[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg <= '0;
        end else begin
            grp_reg <= acc;
        end
    end

    assign grp_res = grp_reg;

endmodule

// ----- hdl/glyph_code_pair_allocator.sv -----
`timescale 1ns / 1ps
// Double-byte glyph code pair allocator.
// Input stream: s_tdata carries lead byte [7:0] and trail byte [15:8];
// s_tuser[0] is the kind (0 record an occurrence, 1 query the pair).
// Output stream: one word per input word with status, the code pair,
// the occurrence count and the table slot (see m_tdata comment).
// The table is a row of cells, one entry each; occupancy passes from cell
// to cell so the first free cell takes a new code.
// Only one word is in flight: a new word is taken once the last has left the
// result stage. The word is taken, the cells compare the key and register their answer,
// groups of 16 cells OR their answers into a register, and the result
// stage updates the table and loads the output register.
// A stalled receiver holds the result stage; s_tready stays low until the
// result stage can load the output register. The waiting output word is held stable.
// Reset empties the table and restarts code allocation at 1; no clearing
// pass is needed, the block is ready in the cycle after reset is released.
module glyph_code_pair_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // lead_byte [7:0], trail_byte [15:8]
    input  logic [0:0]  s_tuser,   // kind [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], code_first [9:2], code_second [17:10],
    // occurrences [33:18], slot [40:34], zero [47:41]
    output logic [47:0] m_tdata
);
    import gcpa_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [15:0]         key_reg;
    logic                kind_reg;
    logic [USED_W-1:0]   used_reg;
    logic [CODE_W-1:0]   next_code_reg;
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;

    logic                accept;
    logic                fire;
    logic                cmp_en;
    cell_cmd_t           cmd;
    logic [TABLE_DEPTH-1:0] occ;
    cell_res_t           res_pad [NUM_GROUPS*GROUP_SIZE];
    cell_res_t           grp_res [NUM_GROUPS];
    cell_res_t           found;

    logic                exhausted;
    logic                alloc;
    logic [CODE_W-1:0]   code_mid;
    logic [CODE_W-1:0]   code_after;
    status_t             res_status;
    logic [15:0]         res_codes;
    logic [15:0]         res_count;
    logic [SLOT_W-1:0]   res_slot;

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < NUM_GROUPS * GROUP_SIZE; gi++) begin : g_cell
            if (gi < TABLE_DEPTH) begin : g_real
                logic prev;
                if (gi == 0) begin : g_head
                    assign prev = 1'b1;
                end else begin : g_link
                    assign prev = occ[gi-1];
                end
                gcpa_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .idx      (SLOT_W'(gi)),
                    .prev_occ (prev),
                    .occ      (occ[gi]),
                    .cmd      (cmd),
                    .res      (res_pad[gi])
                );
            end else begin : g_pad
                assign res_pad[gi] = '0;
            end
        end
        for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_grp
            gcpa_group u_group (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_res (res_pad[gi*GROUP_SIZE +: GROUP_SIZE]),
                .grp_res  (grp_res[gi])
            );
        end
    endgenerate

    always_comb begin
        found = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            found = cell_res_t'(found | grp_res[g]);
        end
    end

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_GRP;
            ST_GRP:  state_next = ST_RES;
            ST_RES:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmp_en   = 1'b0;
        fire     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CMP:  cmp_en   = 1'b1;
            ST_GRP:  ;
            ST_RES:  fire     = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    assign exhausted  = (used_reg >= USED_W'(TABLE_DEPTH)) || next_code_reg[CODE_W-1];
    assign alloc      = (kind_reg == KIND_RECORD) && !found.hit && !exhausted;
    assign code_mid   = advance_code(next_code_reg);
    assign code_after = advance_code(code_mid);

    assign cmd.cmp_en = cmp_en;
    assign cmd.key    = key_reg;
    assign cmd.inc    = fire && (kind_reg == KIND_RECORD);
    assign cmd.wr     = fire && alloc;
    assign cmd.codes  = {code_mid[7:0], next_code_reg[7:0]};

    always_comb begin
        res_status = STAT_HIT;
        res_codes  = 16'd0;
        res_count  = 16'd0;
        res_slot   = '0;
        if (found.hit) begin
            res_codes = found.codes;
            res_slot  = found.slot;
            if (kind_reg == KIND_RECORD && found.count != COUNT_MAX) begin
                res_count = found.count + 16'd1;
            end else begin
                res_count = found.count;
            end
        end else if (kind_reg == KIND_QUERY) begin
            res_status = STAT_MISS;
        end else if (exhausted) begin
            res_status = STAT_FULL;
        end else begin
            res_status = STAT_NEW;
            res_codes  = cmd.codes;
            res_count  = 16'd1;
            res_slot   = used_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            next_code_reg <= CODE_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fire && alloc) begin
                used_reg      <= used_reg + 1'b1;
                next_code_reg <= code_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg  <= {s_tdata[7:0], s_tdata[15:8]};
            kind_reg <= s_tuser[0];
        end
        if (fire) begin
            m_tdata_reg <= {7'd0, 7'(res_slot), res_count, res_codes, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hdl/gcpa_checker.sv -----
`timescale 1ns / 1ps
`include "glyph_code_pair_allocator_defines.svh"
module gcpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import gcpa_pkg::*;

    `GCPA_ASSERT_RST(a_reset_quiet, !aresetn, !m_tvalid, "output word valid after reset")
    `GCPA_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled word changed")
    `GCPA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
        "second word taken while busy")
    `GCPA_ASSERT_IMP(a_new_entry, m_tvalid && m_tdata[1:0] == STAT_NEW,
        m_tdata[33:18] == 16'd1 && m_tdata[9:2] != m_tdata[17:10], "bad new entry word")
    `GCPA_ASSERT_IMP(a_empty_word,
        m_tvalid && (m_tdata[1:0] == STAT_FULL || m_tdata[1:0] == STAT_MISS),
        m_tdata[40:2] == '0, "miss or full word not zero")

endmodule

bind glyph_code_pair_allocator gcpa_checker u_gcpa_checker (.*);
